// File: src/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: item types, held-sequence state,
// decode result and Unicode constants. No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLow     = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHigh    = 21'h00DFFF;
  localparam logic [CpWidth-1:0] Min2        = 21'h000080;
  localparam logic [CpWidth-1:0] Min3        = 21'h000800;
  localparam logic [CpWidth-1:0] Min4        = 21'h010000;

  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // One input item: raw byte plus end-of-string flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               last_of_run;
  } out_item_t;

  // Partial multi-byte sequence carried between items.
  typedef struct packed {
    logic [2:0]         exp_len;
    logic [1:0]         held;
    logic [CpWidth-1:0] value;
  } seq_state_t;

  // Results caused by one item: all are U+FFFD except possibly the last.
  typedef struct packed {
    logic [2:0]         count;
    logic [CpWidth-1:0] last_cp;
  } dec_res_t;

endpackage

`default_nettype wire

// File: src/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: held-sequence state, result register
// and drain counter. Depends on utf8d_pkg and utf8d_decode.
//
//   channel | direction | payload               | handshake
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | utf8d_pkg::in_item_t  | in_valid_i / in_ready_o
//   out     | output    | utf8d_pkg::out_item_t | out_valid_o / out_ready_i
//
// An item is decoded in the cycle it is accepted; its results appear in the
// cycle after, from the result register, one result per cycle while
// out_ready_i is high. An item with zero or one result thus sustains a byte
// a cycle. An item with n results (up to four) holds in_ready_o low while
// the result register drains all but the last; the drain counter sets this.
// Reset closes any open sequence and drops pending results; no clearing pass.
// Output stalls hold the result register; input is taken again as soon as
// the last pending result leaves in the same cycle.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire utf8d_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output utf8d_pkg::out_item_t      out_item_o
);

  utf8d_pkg::seq_state_t         state_q, state_d;
  utf8d_pkg::dec_res_t           dec_res;
  logic [2:0]                    count_q, count_d;
  logic [utf8d_pkg::CpWidth-1:0] cp_q, cp_d;
  logic                          in_fire;
  logic                          out_fire;

  utf8d_decode u_decode (
    .item_i  (in_item_i),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (dec_res)
  );

  // Take a new item once the pending results are gone or the last one leaves now.
  assign in_ready_o  = (count_q == 3'd0) || ((count_q == 3'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_fire    = out_valid_o && out_ready_i;

  // Every result but the last of a run is a replacement character.
  assign out_item_o.code_point  = (count_q == 3'd1) ? cp_q : utf8d_pkg::Replacement;
  assign out_item_o.last_of_run = (count_q == 3'd1);

  always_comb begin
    count_d = count_q;
    cp_d    = cp_q;
    if (in_fire) begin
      // Load the results of the new item.
      count_d = dec_res.count;
      cp_d    = dec_res.last_cp;
    end else if (out_fire) begin
      // Advance to the next pending result.
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= 3'd0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      count_q <= count_d;
    end
  end

  // Payload register: no reset.
  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
  end

endmodule

`default_nettype wire

// File: src/utf8d_decode.sv
// Combinational single-byte decode step for the UTF-8 stream decoder.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode (
  input  wire utf8d_pkg::in_item_t   item_i,
  input  wire utf8d_pkg::seq_state_t state_i,
  output utf8d_pkg::seq_state_t      state_o,
  output utf8d_pkg::dec_res_t        res_o
);

  localparam utf8d_pkg::seq_state_t Closed = '0;

  logic [7:0]                      b;
  logic                            eos;
  logic                            seq_open;
  logic                            is_cont;
  logic                            lead_n;
  logic [utf8d_pkg::CpWidth-1:0]   lead_cp;
  utf8d_pkg::seq_state_t           lead_state;
  logic [utf8d_pkg::CpWidth-1:0]   acc;
  logic [2:0]                      held_inc;
  logic [utf8d_pkg::CpWidth-1:0]   minimum;
  logic                            bad_value;

  assign b   = item_i.data_byte;
  assign eos = item_i.end_of_string;

  assign seq_open = (state_i.exp_len >= utf8d_pkg::Len2) &&
                    (state_i.exp_len <= utf8d_pkg::Len4) &&
                    (state_i.held != 2'd0) &&
                    ({1'b0, state_i.held} < state_i.exp_len);
  assign is_cont  = (b[7:6] == 2'b10);

  // Treat the byte as a lead.
  always_comb begin
    lead_n     = 1'b1;
    lead_cp    = utf8d_pkg::Replacement;
    lead_state = Closed;
    priority casez (b)
      8'b0???????: begin
        lead_cp = {13'd0, b};
      end
      8'b110?????: begin
        lead_n     = eos;
        lead_state = eos ? Closed : '{utf8d_pkg::Len2, 2'd1, {16'd0, b[4:0]}};
      end
      8'b1110????: begin
        lead_n     = eos;
        lead_state = eos ? Closed : '{utf8d_pkg::Len3, 2'd1, {17'd0, b[3:0]}};
      end
      8'b11110???: begin
        lead_n     = eos;
        lead_state = eos ? Closed : '{utf8d_pkg::Len4, 2'd1, {18'd0, b[2:0]}};
      end
      default: begin
        lead_n = 1'b1;
      end
    endcase
  end

  assign acc      = {state_i.value[utf8d_pkg::CpWidth-7:0], b[5:0]};
  assign held_inc = {1'b0, state_i.held} + 3'd1;

  always_comb begin
    unique case (state_i.exp_len)
      utf8d_pkg::Len2: minimum = utf8d_pkg::Min2;
      utf8d_pkg::Len3: minimum = utf8d_pkg::Min3;
      default:         minimum = utf8d_pkg::Min4;
    endcase
  end

  assign bad_value = (acc < minimum) || (acc > utf8d_pkg::MaxScalar) ||
                     ((acc >= utf8d_pkg::SurrLow) && (acc <= utf8d_pkg::SurrHigh));

  always_comb begin
    state_o       = Closed;
    res_o.count   = 3'd0;
    res_o.last_cp = utf8d_pkg::Replacement;
    if (!seq_open) begin
      state_o       = lead_state;
      res_o.count   = {2'd0, lead_n};
      res_o.last_cp = lead_cp;
    end else if (!is_cont) begin
      // Reject every held byte, then decode this byte again as a lead.
      state_o       = lead_state;
      res_o.count   = {1'b0, state_i.held} + {2'd0, lead_n};
      res_o.last_cp = lead_n ? lead_cp : utf8d_pkg::Replacement;
    end else if (held_inc == state_i.exp_len) begin
      res_o.count   = bad_value ? state_i.exp_len : 3'd1;
      res_o.last_cp = bad_value ? utf8d_pkg::Replacement : acc;
    end else if (eos) begin
      res_o.count = held_inc;
    end else begin
      state_o = '{state_i.exp_len, held_inc[1:0], acc};
    end
  end

endmodule

`default_nettype wire

// File: src/utf8d_checker.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire utf8d_pkg::in_item_t  in_item_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire utf8d_pkg::out_item_t out_item_o
);

  // Hold a waiting input item until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("waiting input item changed or dropped");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // Only the last result of a run may carry a decoded value.
  a_fffd_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |->
      out_item_o.code_point == utf8d_pkg::Replacement)
    else $error("non-final result is not a replacement");

  // Never give a value outside the scalar range.
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.code_point <= utf8d_pkg::MaxScalar &&
      !(out_item_o.code_point >= utf8d_pkg::SurrLow &&
        out_item_o.code_point <= utf8d_pkg::SurrHigh))
    else $error("result is not a Unicode scalar value");

  // A new item is taken only when no non-final result is still pending.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> !in_ready_o)
    else $error("input taken while results pending");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
